### rtl/tkl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkl_pkg
// shared types and constants of the top-k-by-length selector
// ----------------------------------------------------------------------------
package tkl_pkg;

  localparam int LEN_W    = 16;
  localparam int HANDLE_W = 16;
  localparam int STAMP_W  = 32;
  localparam int KEEP_W   = 5;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd3;

  // input mode codes
  localparam logic MODE_OFFER = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OFFER,
    S_DRAIN,
    S_SCAN,
    S_REPLACE,
    S_EMIT
  } state_t;

  // one stored entry
  typedef struct packed {
    logic [LEN_W-1:0]    len;
    logic [HANDLE_W-1:0] handle;
    logic [STAMP_W-1:0]  arrival;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic accept;         // latch the request word
    logic scan_start;     // restart the minimum search
    logic scan_run;       // step the minimum search
    logic write_new;      // append into the next free slot
    logic write_replace;  // overwrite the minimum if the request is longer
    logic emit;           // load the minimum into the output register
    logic drain_clear;    // empty the store after the final result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic drain;       // latched request is a drain
    logic limit_zero;  // keep count is zero
    logic full;        // kept total has reached the limit
    logic empty;       // nothing kept
    logic scan_done;   // minimum search finished
    logic out_free;    // output register can take a word
    logic last_pick;   // the pending result is the final one
  } status_t;

endpackage
`default_nettype wire

### rtl/tkl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkl_ctrl
// sequencer for offers, minimum searches and drain runs
// ----------------------------------------------------------------------------
module tkl_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             mode,
  input  wire tkl_pkg::status_t status,
  output tkl_pkg::cmd_t         cmd,
  output logic                  in_ready
);

  tkl_pkg::state_t state;
  tkl_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tkl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      tkl_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = (mode == tkl_pkg::MODE_DRAIN) ? tkl_pkg::S_DRAIN : tkl_pkg::S_OFFER;
        end
      end
      tkl_pkg::S_OFFER: begin
        if (status.limit_zero) begin
          state_next = tkl_pkg::S_IDLE;
        end else if (!status.full) begin
          cmd.write_new = 1'b1;
          state_next    = tkl_pkg::S_IDLE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = tkl_pkg::S_SCAN;
        end
      end
      tkl_pkg::S_DRAIN: begin
        if (status.empty) begin
          state_next = tkl_pkg::S_IDLE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = tkl_pkg::S_SCAN;
        end
      end
      tkl_pkg::S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (status.scan_done) begin
          state_next = status.drain ? tkl_pkg::S_EMIT : tkl_pkg::S_REPLACE;
        end
      end
      tkl_pkg::S_REPLACE: begin
        cmd.write_replace = 1'b1;
        state_next        = tkl_pkg::S_IDLE;
      end
      tkl_pkg::S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last_pick) begin
            cmd.drain_clear = 1'b1;
            state_next      = tkl_pkg::S_IDLE;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = tkl_pkg::S_SCAN;
          end
        end
      end
      default: begin
        state_next = tkl_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/tkl_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkl_datapath
// entry memory, minimum search, counters and output register
// ----------------------------------------------------------------------------
module tkl_datapath #(
  parameter int CAPACITY = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire tkl_pkg::cmd_t                cmd,
  output tkl_pkg::status_t                  status,
  input  wire logic                         cfg_write,
  input  wire logic [tkl_pkg::KEEP_W-1:0]   cfg_data,
  input  wire logic                         mode,
  input  wire logic [tkl_pkg::HANDLE_W-1:0] word_handle,
  input  wire logic [tkl_pkg::LEN_W-1:0]    word_length,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [tkl_pkg::HANDLE_W-1:0]      kept_handle,
  output logic [tkl_pkg::LEN_W-1:0]         kept_length,
  output logic                              last_of_drain
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = (CNT_W > tkl_pkg::KEEP_W) ? CNT_W : tkl_pkg::KEEP_W;

  logic [tkl_pkg::KEEP_W-1:0]   keep_count;
  logic [CNT_W-1:0]             kept_total;
  logic [tkl_pkg::STAMP_W-1:0]  arrival_counter;

  logic                         req_mode;
  logic [tkl_pkg::HANDLE_W-1:0] req_handle;
  logic [tkl_pkg::LEN_W-1:0]    req_length;
  logic [tkl_pkg::STAMP_W-1:0]  req_stamp;

  tkl_pkg::entry_t              mem [CAPACITY];
  tkl_pkg::entry_t              rd_data;
  tkl_pkg::entry_t              wr_data;
  logic                         mem_we;
  logic [IDX_W-1:0]             wr_idx;

  logic [CAPACITY-1:0]          taken;
  logic [CNT_W-1:0]             scan_idx;
  logic [IDX_W-1:0]             rd_idx;
  logic                         rd_valid;
  logic                         issue;

  logic                         best_valid;
  logic [IDX_W-1:0]             best_idx;
  tkl_pkg::entry_t              best;
  logic                         rd_before;

  logic [CNT_W-1:0]             drain_count;

  logic [CMP_W-1:0]             limit;
  logic [CMP_W-1:0]             kc_w;
  logic                         longer;

  // effective limit is the keep count clipped to capacity
  always_comb begin
    kc_w  = CMP_W'(keep_count);
    limit = (kc_w > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : kc_w;
  end

  assign longer = req_length > best.len;
  assign issue  = cmd.scan_run && (scan_idx < kept_total);

  // shorter first, then earlier arrival
  assign rd_before = (rd_data.len < best.len) ||
                     ((rd_data.len == best.len) && (rd_data.arrival < best.arrival));

  always_comb begin
    status.drain      = req_mode;
    status.limit_zero = (limit == '0);
    status.full       = (CMP_W'(kept_total) >= limit);
    status.empty      = (kept_total == '0);
    status.scan_done  = (scan_idx == kept_total) && !rd_valid;
    status.out_free   = !out_valid || out_ready;
    status.last_pick  = ((drain_count + CNT_W'(1)) == kept_total);
  end

  assign mem_we  = cmd.write_new || (cmd.write_replace && longer);
  assign wr_idx  = cmd.write_new ? kept_total[IDX_W-1:0] : best_idx;
  assign wr_data = '{len: req_length, handle: req_handle, arrival: req_stamp};

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data <= mem[scan_idx[IDX_W-1:0]];
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_mode   <= mode;
      req_handle <= word_handle;
      req_length <= word_length;
      req_stamp  <= arrival_counter;
    end
  end

  // configuration and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count      <= tkl_pkg::KEEP_RESET;
      kept_total      <= '0;
      arrival_counter <= '0;
      drain_count     <= '0;
    end else begin
      if (cfg_write) begin
        keep_count <= cfg_data;
      end
      if (cmd.accept && (mode == tkl_pkg::MODE_OFFER)) begin
        arrival_counter <= arrival_counter + tkl_pkg::STAMP_W'(1);
      end
      if (cmd.accept) begin
        drain_count <= '0;
      end else if (cmd.emit) begin
        drain_count <= drain_count + CNT_W'(1);
      end
      if (cmd.write_new) begin
        kept_total <= kept_total + CNT_W'(1);
      end else if (cmd.drain_clear) begin
        kept_total <= '0;
      end
    end
  end

  // minimum search over the untaken entries
  // the index returns to zero with an emptied store so it never passes the total
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      rd_valid   <= 1'b0;
      best_valid <= 1'b0;
      taken      <= '0;
    end else begin
      if (cmd.scan_start || cmd.drain_clear) begin
        scan_idx   <= '0;
        rd_valid   <= 1'b0;
        best_valid <= 1'b0;
      end else begin
        rd_valid <= issue;
        if (issue) begin
          scan_idx <= scan_idx + CNT_W'(1);
        end
        if (cmd.scan_run && rd_valid && !taken[rd_idx] && (!best_valid || rd_before)) begin
          best_valid <= 1'b1;
        end
      end
      if (cmd.drain_clear) begin
        taken <= '0;
      end else if (cmd.emit) begin
        taken[best_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_idx <= scan_idx[IDX_W-1:0];
    end
    if (!cmd.scan_start && cmd.scan_run && rd_valid && !taken[rd_idx] &&
        (!best_valid || rd_before)) begin
      best     <= rd_data;
      best_idx <= rd_idx;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kept_handle   <= best.handle;
      kept_length   <= best.len;
      last_of_drain <= status.last_pick;
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    kept_total <= CNT_W'(CAPACITY))
    else $error("kept total above capacity");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (status.out_free && best_valid))
    else $error("emit without a free output or a found minimum");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.write_new |-> (!status.full && !status.limit_zero))
    else $error("append into a full store");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    scan_idx <= kept_total)
    else $error("search index past kept total");

endmodule
`default_nettype wire

### rtl/top_k_by_length_selector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// top_k_by_length_selector
// keeps the keep_count (at most CAPACITY) longest offered words and drains them sorted
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready): mode 0 offers a word (word_handle,
//   word_length), mode 1 drains. offers give no output word.
//   output channel (out_valid/out_ready): one word per kept entry during a
//   drain, ascending length, ties oldest first, last_of_drain on the final one.
//   config channel (cfg_valid/cfg_ready, data keep_count) is always ready;
//   write it only while the block is idle. keep_count resets to 3.
// sequence of each request:
//   offer into a store below its limit: append into the next free slot
//   offer into a full store: a minimum search that walks the entry memory
//   through its single read port, then a replace if the offer is longer
//   drain: a new minimum search over the untaken entries per output word
//   empty drain: no output word
// reset clears the kept total, the arrival counter and the output valid;
// entry memory needs no clearing since only reads of kept slots are ever used.
// a stalled receiver holds the output register; the search for the next
// result waits before loading it, and after the final word the block
// already takes the next input word.
// ----------------------------------------------------------------------------
module top_k_by_length_selector #(
  parameter int CAPACITY = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // configuration
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [tkl_pkg::KEEP_W-1:0]   keep_count,
  // input words
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         mode,
  input  wire logic [tkl_pkg::HANDLE_W-1:0] word_handle,
  input  wire logic [tkl_pkg::LEN_W-1:0]    word_length,
  // output words
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [tkl_pkg::HANDLE_W-1:0]      kept_handle,
  output logic [tkl_pkg::LEN_W-1:0]         kept_length,
  output logic                              last_of_drain
);

  tkl_pkg::cmd_t    cmd;
  tkl_pkg::status_t status;

  // register write never stalls
  assign cfg_ready = 1'b1;

  // sequencer
  tkl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .status   (status),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  // storage, search and output register
  tkl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_write     (cfg_valid && cfg_ready),
    .cfg_data      (keep_count),
    .mode          (mode),
    .word_handle   (word_handle),
    .word_length   (word_length),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kept_handle   (kept_handle),
    .kept_length   (kept_length),
    .last_of_drain (last_of_drain)
  );

endmodule
`default_nettype wire
